FILE: rtl/srgb_ovl_pkg.sv
// package for the srgb overlay over linear video compositor
// holds field widths, fixed-point constants and the srgb-to-linear decode table
// no dependencies; read before the interfaces and the core
package srgb_ovl_pkg;

  // field widths
  localparam int VIDEO_W = 16;
  localparam int ALPHA_W = 13;
  localparam int OVL_W   = 8;
  localparam int WS_W    = 16;
  localparam int ROM_W   = 17;

  // register reset and fixed-point constants
  localparam logic [WS_W-1:0]    WHITE_SCALE_RESET = 16'd4096;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE         = 13'd4096;
  // floor(2^24 / 255), used for divide-by-255 with one correction step
  localparam logic [16:0]        RECIP_255         = 17'd65793;
  // 255 * 32768: half of the color divisor after the 16-bit shift, also the sign bias
  localparam logic [25:0]        COLOR_BIAS        = 26'd8355840;

  // pipeline depth of the core
  localparam int PIPE_STAGES = 9;

  // srgb decode table, unsigned q16 (65536 is 1.0)
  typedef logic [ROM_W-1:0] srgb_rom_t [256];

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  // built at elaboration: linear segment for small codes, power segment
  // through a bitwise search for the fifth root in q30
  function automatic srgb_rom_t build_srgb_rom();
    srgb_rom_t   t;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] r;
    logic [63:0] cand;
    logic [63:0] p;
    for (int i = 0; i < 256; i++) begin
      if (i <= 10) begin
        t[i] = ROM_W'((64'(i) * 64'd6553600 + 64'd164730) / 64'd329460);
      end else begin
        y  = ((64'd1000 * 64'(i) + 64'd14025) << 30) / 64'd269025;
        y2 = (y * y) >> 30;
        r  = 64'd0;
        for (int b = 30; b >= 0; b--) begin
          cand = r | (64'd1 << b);
          if (cand <= ONE_Q30) begin
            p = cand;
            for (int k = 0; k < 4; k++) begin
              p = (p * cand) >> 30;
            end
            if (p <= y2) begin
              r = cand;
            end
          end
        end
        t[i] = ROM_W'((((y2 * r) >> 30) + 64'd8192) >> 14);
      end
    end
    return t;
  endfunction

  localparam srgb_rom_t SRGB_ROM = build_srgb_rom();

endpackage

FILE: rtl/srgb_ovl_if.sv
// valid/ready channel interfaces of the compositor: pixel in, pixel out, config
// depends on srgb_ovl_pkg for the field widths
interface sov_pix_in_if import srgb_ovl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VIDEO_W-1:0] video_red;
  logic signed [VIDEO_W-1:0] video_green;
  logic signed [VIDEO_W-1:0] video_blue;
  logic        [ALPHA_W-1:0] video_alpha;
  logic        [OVL_W-1:0]   overlay_red;
  logic        [OVL_W-1:0]   overlay_green;
  logic        [OVL_W-1:0]   overlay_blue;
  logic        [OVL_W-1:0]   overlay_alpha;

  modport source (
    output valid, video_red, video_green, video_blue, video_alpha,
           overlay_red, overlay_green, overlay_blue, overlay_alpha,
    input  ready
  );
  modport sink (
    input  valid, video_red, video_green, video_blue, video_alpha,
           overlay_red, overlay_green, overlay_blue, overlay_alpha,
    output ready
  );
endinterface

interface sov_pix_out_if import srgb_ovl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VIDEO_W-1:0] out_red;
  logic signed [VIDEO_W-1:0] out_green;
  logic signed [VIDEO_W-1:0] out_blue;
  logic        [ALPHA_W-1:0] out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface sov_cfg_if import srgb_ovl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [WS_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: rtl/srgb_overlay_over_linear_video_core.sv
// top level of the srgb overlay over linear video compositor
// depends on srgb_ovl_pkg and the channel interfaces in srgb_ovl_if.sv
//
// Takes one pixel per clock while the output is ready and returns its composite; every
// pixel is independent, so the nine-stage pipeline sustains one item per cycle.
// Stages: 1 unpremultiply numerator and alpha sum, 2-3 the 8-bit divide of the
// overlay color by its alpha (four quotient bits per stage) and the alpha
// divide by 255, 4 decode table read, 5-6 the alpha and white-scale products,
// 7 color sum, 8-9 the divide by 255 with rounding and saturation. Each stage
// has its own valid bit and may fill while the stages after it are stalled,
// so a result waiting at the output does not block input until the pipe is
// full. The white scale register is written through the config channel, which
// is always ready; write it only while no pixel is in flight.
module srgb_overlay_over_linear_video_core import srgb_ovl_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  sov_cfg_if.sink       cfg,
  sov_pix_in_if.sink    pix_in,
  sov_pix_out_if.source pix_out
);

  localparam int N = PIPE_STAGES;

  // pipeline control
  logic [N:1]   vld;
  logic [N:1]   vin;
  logic [N+1:1] rdy;

  // configuration register
  logic [WS_W-1:0] white_scale;

  // per-stage payload, three color lanes
  logic        [15:0]        n1      [3];
  logic signed [VIDEO_W-1:0] vid1    [3];
  logic        [7:0]         a1;
  logic        [21:0]        ax1;

  logic        [7:0]         rem2    [3];
  logic        [3:0]         qhi2    [3];
  logic        [3:0]         nlo2    [3];
  logic                      sat2    [3];
  logic signed [VIDEO_W-1:0] vid2    [3];
  logic        [7:0]         a2;
  logic        [21:0]        ax2;
  logic        [14:0]        aq0_2;

  logic        [7:0]         idx3    [3];
  logic signed [VIDEO_W-1:0] vid3    [3];
  logic        [7:0]         a3;
  logic        [ALPHA_W-1:0] aout3;

  logic        [ROM_W-1:0]   rom4    [3];
  logic signed [24:0]        vm4     [3];
  logic        [7:0]         a4;
  logic        [ALPHA_W-1:0] aout4;

  logic        [23:0]        pa5     [3];
  logic signed [24:0]        vm5     [3];
  logic        [ALPHA_W-1:0] aout5;

  logic        [39:0]        p6      [3];
  logic signed [24:0]        vm6     [3];
  logic        [ALPHA_W-1:0] aout6;

  logic        [24:0]        x7      [3];
  logic        [ALPHA_W-1:0] aout7;

  logic        [17:0]        q8      [3];
  logic        [24:0]        x8      [3];
  logic        [ALPHA_W-1:0] aout8;

  logic signed [VIDEO_W-1:0] col9    [3];
  logic        [ALPHA_W-1:0] aout9;

  // combinational helpers
  logic        [OVL_W-1:0]   ovl_in  [3];
  logic signed [VIDEO_W-1:0] vid_in  [3];
  logic        [11:0]        div_hi  [3];
  logic        [11:0]        div_lo  [3];
  logic        [38:0]        aprod;
  logic        [21:0]        ab255;
  logic        [21:0]        arem;
  logic        [14:0]        aq;
  logic        [39:0]        psum    [3];
  logic signed [25:0]        xs      [3];
  logic        [41:0]        cprod   [3];
  logic        [24:0]        cb255   [3];
  logic        [24:0]        crem    [3];
  logic        [17:0]        cq      [3];

  // four restoring divide steps; remainder in the high byte, quotient bits below
  function automatic logic [11:0] div4(input logic [7:0] rem_in, input logic [3:0] bits,
                                       input logic [7:0] den);
    logic [8:0] r;
    logic [7:0] rr;
    logic [3:0] q;
    rr = rem_in;
    q  = 4'd0;
    for (int k = 3; k >= 0; k--) begin
      r = {rr, bits[k]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[k] = 1'b1;
      end
      rr = r[7:0];
    end
    return {rr, q};
  endfunction

  // config channel is always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      white_scale <= WHITE_SCALE_RESET;
    end else if (cfg.valid) begin
      white_scale <= cfg.data;
    end
  end

  // stage ready chain: a stage loads when empty or when its item moves on
  always_comb begin
    rdy[N+1] = pix_out.ready;
    for (int k = N; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign vin          = {vld[N-1:1], pix_in.valid};
  assign pix_in.ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= N; k++) begin
        if (rdy[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  // lane view of the input item
  always_comb begin
    ovl_in[0] = pix_in.overlay_red;
    ovl_in[1] = pix_in.overlay_green;
    ovl_in[2] = pix_in.overlay_blue;
    vid_in[0] = pix_in.video_red;
    vid_in[1] = pix_in.video_green;
    vid_in[2] = pix_in.video_blue;
  end

  // stage 1: unpremultiply numerator c*255 + a/2 and alpha composite sum
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        n1[i]   <= ({ovl_in[i], 8'd0} - 16'(ovl_in[i])) + 16'(pix_in.overlay_alpha[7:1]);
        vid1[i] <= vid_in[i];
      end
      a1  <= pix_in.overlay_alpha;
      ax1 <= {2'd0, pix_in.overlay_alpha, 12'd0}
             + 22'(pix_in.video_alpha) * {14'd0, ~pix_in.overlay_alpha} + 22'd127;
    end
  end

  // stage 2: high quotient bits, saturation check, alpha reciprocal estimate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_hi[i] = div4(n1[i][15:8], n1[i][7:4], a1);
    end
    aprod = 39'(ax1) * 39'(RECIP_255);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        rem2[i] <= div_hi[i][11:4];
        qhi2[i] <= div_hi[i][3:0];
        nlo2[i] <= n1[i][3:0];
        sat2[i] <= n1[i] >= {a1, 8'd0};
        vid2[i] <= vid1[i];
      end
      a2    <= a1;
      ax2   <= ax1;
      aq0_2 <= aprod[38:24];
    end
  end

  // stage 3: low quotient bits, alpha quotient correction and clamp
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_lo[i] = div4(rem2[i], nlo2[i], a2);
    end
    ab255 = 22'(aq0_2) * 22'd255;
    arem  = ax2 - ab255;
    aq    = (arem >= 22'd255) ? aq0_2 + 15'd1 : aq0_2;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        idx3[i] <= sat2[i] ? 8'hFF : {qhi2[i], div_lo[i][3:0]};
        vid3[i] <= vid2[i];
      end
      a3    <= a2;
      aout3 <= (aq > 15'(ALPHA_ONE)) ? ALPHA_ONE : aq[ALPHA_W-1:0];
    end
  end

  // stage 4: decode table read, video weight v*(255-a)
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int i = 0; i < 3; i++) begin
        rom4[i] <= SRGB_ROM[idx3[i]];
        vm4[i]  <= vid3[i] * $signed({1'b0, ~a3});
      end
      a4    <= a3;
      aout4 <= aout3;
    end
  end

  // stage 5: decoded color times overlay alpha (zero alpha drops the overlay)
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int i = 0; i < 3; i++) begin
        pa5[i] <= 24'(rom4[i]) * 24'(a4);
        vm5[i] <= vm4[i];
      end
      aout5 <= aout4;
    end
  end

  // stage 6: times white scale
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int i = 0; i < 3; i++) begin
        p6[i]  <= 40'(pa5[i]) * 40'(white_scale);
        vm6[i] <= vm5[i];
      end
      aout6 <= aout5;
    end
  end

  // stage 7: color sum over 65536 with rounding bias, shifted non-negative
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = p6[i] + 40'(COLOR_BIAS);
      xs[i]   = 26'(vm6[i]) + $signed(COLOR_BIAS) + $signed({2'd0, psum[i][39:16]});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      for (int i = 0; i < 3; i++) begin
        x7[i] <= xs[i][24:0];
      end
      aout7 <= aout6;
    end
  end

  // stage 8: reciprocal estimate of x / 255
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cprod[i] = 42'(x7[i]) * 42'(RECIP_255);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      for (int i = 0; i < 3; i++) begin
        q8[i] <= cprod[i][41:24];
        x8[i] <= x7[i];
      end
      aout8 <= aout7;
    end
  end

  // stage 9: quotient correction, remove bias, saturate to signed 16 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cb255[i] = 25'(q8[i]) * 25'd255;
      crem[i]  = x8[i] - cb255[i];
      cq[i]    = (crem[i] >= 25'd255) ? q8[i] + 18'd1 : q8[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      for (int i = 0; i < 3; i++) begin
        if (cq[i] >= 18'd65536) begin
          col9[i] <= 16'sh7FFF;
        end else begin
          col9[i] <= $signed({~cq[i][15], cq[i][14:0]});
        end
      end
      aout9 <= aout8;
    end
  end

  // output item
  assign pix_out.valid     = vld[N];
  assign pix_out.out_red   = col9[0];
  assign pix_out.out_green = col9[1];
  assign pix_out.out_blue  = col9[2];
  assign pix_out.out_alpha = aout9;

  // unsaturated divide keeps its partial remainder below the overlay alpha
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[2] && !sat2[0] |-> rem2[0] < a2)
    else $error("overlay divide remainder not below alpha");

  // one correction step is enough for the alpha divide by 255
  a_alpha_corr: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> arem < 22'd510)
    else $error("alpha reciprocal estimate off by more than one");

  // one correction step is enough for the color divide by 255
  a_color_corr: assert property (@(posedge clk) disable iff (rst)
    vld[8] |-> crem[0] < 25'd510 && crem[1] < 25'd510 && crem[2] < 25'd510)
    else $error("color reciprocal estimate off by more than one");

  // composited alpha never exceeds opaque
  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> pix_out.out_alpha <= ALPHA_ONE)
    else $error("output alpha above one");

endmodule
